[hw/rtl/ipv4hc_pkg.sv]
package ipv4hc_pkg;

  localparam int BASE_HEADER_BYTES = 20;
  localparam int POS_W = 6;
  localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BASE_SHORT  = 3'd1,
    ST_OPT_SHORT   = 3'd2,
    ST_LEN_UNDER   = 3'd3,
    ST_BAD_CHECK   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [15:0] frag_field;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } result_t;

endpackage

[hw/rtl/ipv4_header_receive_check_unit.sv]
// out_tvalid is registered: it rises in the cycle after the accepted byte that completes a result
// throughput: one byte per cycle while in_tready is high; the output register is refilled in the cycle it is taken
// reset: synchronous active-low rst_n clears the byte count, running sum and output valid
// header byte store is not reset and is written before any result uses it
module ipv4_header_receive_check_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // version, header_words, service_type, total_length,
                                   // ident, frag_field, ttl, protocol, source_addr, dest_addr
  output logic [2:0]   out_tuser   // status
);

  logic                item_acc;
  logic                res_valid;
  ipv4hc_pkg::result_t res;
  ipv4hc_pkg::result_t out_r;
  logic                out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign item_acc  = in_tvalid && in_tready;

  ipv4hc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_acc       (item_acc),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (item_acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {out_r.dest_addr, out_r.source_addr, out_r.protocol, out_r.ttl,
                       out_r.frag_field, out_r.ident, out_r.total_length,
                       out_r.service_type, out_r.header_words, out_r.version};

endmodule

[hw/rtl/ipv4hc_core.sv]
module ipv4hc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_acc,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_message,
  output logic                 res_valid,
  output ipv4hc_pkg::result_t  res
);

  logic [ipv4hc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                  sum_r, sum_nxt;
  logic [7:0]                   pend_r, pend_nxt;
  logic                         given_r, given_nxt;
  logic [7:0]                   hdr_r [ipv4hc_pkg::BASE_HEADER_BYTES];
  logic [7:0]                   hdr_v [ipv4hc_pkg::BASE_HEADER_BYTES];

  logic                         active;
  logic [ipv4hc_pkg::POS_W:0]   pos_inc;
  logic [3:0]                   words;
  logic [16:0]                  sum_add;
  logic [15:0]                  sum_fold;
  logic                         hit_len, hit_end;

  // header bytes as they stand after this item
  always_comb begin
    for (int i = 0; i < ipv4hc_pkg::BASE_HEADER_BYTES; i++) begin
      hdr_v[i] = (pos_r == ipv4hc_pkg::POS_W'(i)) ? data_byte : hdr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ipv4hc_pkg::BASE_HEADER_BYTES; i++) begin
      if (active && pos_r == ipv4hc_pkg::POS_W'(i)) begin
        hdr_r[i] <= data_byte;
      end
    end
  end

  assign active   = item_acc && !given_r;
  assign pos_inc  = {1'b0, pos_r} + (ipv4hc_pkg::POS_W+1)'(1);
  assign words    = hdr_v[0][3:0];
  assign sum_add  = {1'b0, sum_r} + {1'b0, pend_r, data_byte};
  assign sum_fold = sum_add[15:0] + 16'(sum_add[16]);

  assign hit_len = (pos_inc == (ipv4hc_pkg::POS_W+1)'(ipv4hc_pkg::BASE_HEADER_BYTES))
                   && (words < ipv4hc_pkg::MIN_HEADER_WORDS);
  assign hit_end = (words >= ipv4hc_pkg::MIN_HEADER_WORDS)
                   && (pos_inc == {1'b0, words, 2'b00});

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    given_nxt = given_r;
    if (active) begin
      pos_nxt = pos_inc[ipv4hc_pkg::POS_W-1:0];
      if (pos_r[0]) begin
        sum_nxt = sum_fold;
      end else begin
        pend_nxt = data_byte;
      end
      given_nxt = hit_len || hit_end;
    end
    if (item_acc && end_of_message) begin
      pos_nxt   = '0;
      sum_nxt   = '0;
      pend_nxt  = '0;
      given_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      pend_r  <= '0;
      given_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
      given_r <= given_nxt;
    end
  end

  assign res_valid = active && (hit_len || hit_end || end_of_message);

  always_comb begin
    res              = '0;
    res.version      = hdr_v[0][7:4];
    res.header_words = hdr_v[0][3:0];
    res.service_type = hdr_v[1];
    res.total_length = {hdr_v[2], hdr_v[3]};
    res.ident        = {hdr_v[4], hdr_v[5]};
    res.frag_field   = {hdr_v[6], hdr_v[7]};
    res.ttl          = hdr_v[8];
    res.protocol     = hdr_v[9];
    res.source_addr  = {hdr_v[12], hdr_v[13], hdr_v[14], hdr_v[15]};
    res.dest_addr    = {hdr_v[16], hdr_v[17], hdr_v[18], hdr_v[19]};
    if (hit_len) begin
      res.status = ipv4hc_pkg::ST_LEN_UNDER;
    end else if (hit_end) begin
      res.status = (sum_fold == ipv4hc_pkg::SUM_GOOD) ? ipv4hc_pkg::ST_OK
                                                      : ipv4hc_pkg::ST_BAD_CHECK;
    end else if (pos_inc < (ipv4hc_pkg::POS_W+1)'(ipv4hc_pkg::BASE_HEADER_BYTES)) begin
      res        = '0;
      res.status = ipv4hc_pkg::ST_BASE_SHORT;
    end else begin
      res.status = ipv4hc_pkg::ST_OPT_SHORT;
    end
  end

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] bytes_t[$];

  class header_status_tracker;
    ipv4hc_pkg::result_t expected_results[$];
    int          errors;
    int          pos;
    logic [15:0] sum;
    logic [7:0]  hi_byte;
    logic [7:0]  hdr[ipv4hc_pkg::BASE_HEADER_BYTES];
    bit          done;

    function void clear_message();
      pos = 0;
      sum = '0;
      hi_byte = '0;
      done = 0;
    endfunction

    function ipv4hc_pkg::result_t header_fields(ipv4hc_pkg::status_t st);
      ipv4hc_pkg::result_t r;
      r = '0;
      r.status = st;
      r.version = hdr[0][7:4];
      r.header_words = hdr[0][3:0];
      r.service_type = hdr[1];
      r.total_length = {hdr[2], hdr[3]};
      r.ident = {hdr[4], hdr[5]};
      r.frag_field = {hdr[6], hdr[7]};
      r.ttl = hdr[8];
      r.protocol = hdr[9];
      r.source_addr = {hdr[12], hdr[13], hdr[14], hdr[15]};
      r.dest_addr = {hdr[16], hdr[17], hdr[18], hdr[19]};
      return r;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      ipv4hc_pkg::result_t r;
      bit          have;
      logic [16:0] acc;
      logic [3:0]  words;
      have = 0;
      r = '0;
      if (!done) begin
        if (pos < ipv4hc_pkg::BASE_HEADER_BYTES) hdr[pos] = b;
        if (pos % 2 == 0) begin
          hi_byte = b;
        end else begin
          acc = {1'b0, sum} + {1'b0, hi_byte, b};
          sum = acc[15:0] + 16'(acc[16]);
        end
        pos++;
        if (pos >= ipv4hc_pkg::BASE_HEADER_BYTES) begin
          words = hdr[0][3:0];
          if (pos == ipv4hc_pkg::BASE_HEADER_BYTES && words < ipv4hc_pkg::MIN_HEADER_WORDS) begin
            r = header_fields(ipv4hc_pkg::ST_LEN_UNDER);
            have = 1;
          end else if (words >= ipv4hc_pkg::MIN_HEADER_WORDS && pos == int'(words) * 4) begin
            r = header_fields(sum == ipv4hc_pkg::SUM_GOOD ? ipv4hc_pkg::ST_OK
                                                          : ipv4hc_pkg::ST_BAD_CHECK);
            have = 1;
          end
        end
        if (have) begin
          done = 1;
        end else if (last) begin
          if (pos < ipv4hc_pkg::BASE_HEADER_BYTES) r.status = ipv4hc_pkg::ST_BASE_SHORT;
          else r = header_fields(ipv4hc_pkg::ST_OPT_SHORT);
          have = 1;
        end
      end
      if (have) expected_results.push_back(r);
      if (last) clear_message();
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t ns: %s expected %h got %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void match_result(logic [143:0] data, logic [2:0] user);
      ipv4hc_pkg::result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result expected none got status %h data %h",
                 $time, user, data);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      cmp_field("status", 32'(e.status), 32'(user));
      cmp_field("version", 32'(e.version), 32'(data[3:0]));
      cmp_field("header_words", 32'(e.header_words), 32'(data[7:4]));
      cmp_field("service_type", 32'(e.service_type), 32'(data[15:8]));
      cmp_field("total_length", 32'(e.total_length), 32'(data[31:16]));
      cmp_field("ident", 32'(e.ident), 32'(data[47:32]));
      cmp_field("frag_field", 32'(e.frag_field), 32'(data[63:48]));
      cmp_field("ttl", 32'(e.ttl), 32'(data[71:64]));
      cmp_field("protocol", 32'(e.protocol), 32'(data[79:72]));
      cmp_field("source_addr", e.source_addr, data[111:80]);
      cmp_field("dest_addr", e.dest_addr, data[143:112]);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [2:0]   out_tuser;

  header_status_tracker tracker;
  int in_idle_pct;
  int out_stall_pct;
  int bytes_sent;
  int msgs_sent;

  ipv4_header_receive_check_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_result(out_tdata, out_tuser);
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bytes_t make_message(logic [3:0] ver, logic [3:0] words, bit good,
                                          int payload);
    bytes_t      m;
    int          len;
    int          k;
    logic [15:0] sum;
    logic [16:0] acc;
    len = (words < ipv4hc_pkg::MIN_HEADER_WORDS) ? ipv4hc_pkg::BASE_HEADER_BYTES
                                                 : int'(words) * 4;
    for (int i = 0; i < len + payload; i++) m.push_back(8'($urandom_range(255)));
    m[0] = {ver, words};
    m[10] = '0;
    m[11] = '0;
    sum = '0;
    for (int i = 0; i < len; i += 2) begin
      acc = {1'b0, sum} + {1'b0, m[i], m[i + 1]};
      sum = acc[15:0] + 16'(acc[16]);
    end
    m[10] = ~sum[15:8];
    m[11] = ~sum[7:0];
    if (!good) begin
      k = $urandom_range(len - 1, 1);
      m[k] = m[k] ^ (8'd1 << $urandom_range(7));
    end
    return m;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(bytes_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    msgs_sent++;
  endtask

  task automatic send_cut(bytes_t m, int keep);
    m = m[0:keep - 1];
    send_message(m);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_message();
    bytes_t     m;
    int         r;
    logic [3:0] words;
    r = $urandom_range(99);
    words = ($urandom_range(9) < 7) ? ipv4hc_pkg::MIN_HEADER_WORDS
                                    : 4'($urandom_range(15, 6));
    if (r < 55) begin
      send_message(make_message(4'($urandom_range(15)), words, 1, $urandom_range(6)));
    end else if (r < 67) begin
      send_message(make_message(4'($urandom_range(15)), words, 0, $urandom_range(6)));
    end else if (r < 77) begin
      send_message(make_message(4'($urandom_range(15)), 4'($urandom_range(4)), 1,
                                $urandom_range(3)));
    end else if (r < 90) begin
      m = make_message(4'($urandom_range(15)), words, $urandom_range(1), 0);
      send_cut(m, $urandom_range(m.size() - 1, 1));
    end else begin
      for (int i = 0; i < $urandom_range(64, 1); i++) m.push_back(8'($urandom_range(255)));
      send_message(m);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_bytes);
    int start_bytes;
    int start_msgs;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    start_bytes = bytes_sent;
    start_msgs = msgs_sent;
    while (bytes_sent - start_bytes < n_bytes || msgs_sent - start_msgs < 4) random_message();
    drain_results();
  endtask

  initial begin
    bytes_t m;
    tracker = new();
    tracker.clear_message();
    in_idle_pct = 0;
    out_stall_pct = 0;
    bytes_sent = 0;
    msgs_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // good header ending on its last byte, then bad checksum with payload
    send_message(make_message(4'd4, ipv4hc_pkg::MIN_HEADER_WORDS, 1, 0));
    send_message(make_message(4'd4, ipv4hc_pkg::MIN_HEADER_WORDS, 0, 3));
    // length nibble under five, one ending exactly at the base header
    m = make_message(4'd0, 4'd0, 1, 0);
    for (int i = 0; i < m.size(); i++) m[i] = (i == 0) ? 8'h00 : 8'hFF;
    send_message(m);
    send_message(make_message(4'd4, 4'd4, 1, 2));
    // maximum options with all ones in the first byte
    send_message(make_message(4'hF, 4'hF, 1, 1));
    // options short, base header short
    send_cut(make_message(4'd4, 4'd8, 1, 0), 25);
    send_cut(make_message(4'd4, ipv4hc_pkg::MIN_HEADER_WORDS, 1, 0), 19);
    send_message('{8'h45});
    drain_results();

    run_phase(0, 0, 130);
    run_phase(83, 0, 130);
    run_phase(0, 83, 130);
    run_phase(23, 23, 130);

    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
